// ===== rtl/aes_pkg.sv =====
package aes_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_ROUND,
		ST_DONE
	} state_t;

	localparam int KeyWidth = 128;

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [0:255];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		return t[x];
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// byte i of the block sits at bits 127-8i
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (r + 4 * c) -: 8] = sbox(s[127 - 8 * (r + 4 * ((c + r) % 4)) -: 8]);
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix_columns(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, all;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			all = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
			t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
			t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
			t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
		end
		return t;
	endfunction

endpackage

// ===== rtl/aes_ram.sv =====
module aes_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 11
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end
endmodule

// ===== rtl/aes128_ecb_encrypt.sv =====
// channel | signals                                                     | direction
// in      | in_valid, in_stall, command, round_index, data_high,
//         | data_low, last_block                                        | into block
// out     | out_valid, out_stall, cipher_high, cipher_low, last_out     | out of block
// An encrypt shows its result after one key memory read, then one round per cycle on
// the shared round unit. The final key add is applied on the output while key ROUNDS
// sits on the read port. The next word is taken the cycle after the result leaves.
// Reset clears control only; keys stay undefined until stored. A stalled result
// holds; no new word is taken until it leaves.
module aes128_ecb_encrypt #(
	parameter int ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [3:0]  round_index,
	input  logic [63:0] data_high,
	input  logic [63:0] data_low,
	input  logic        last_block,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] cipher_high,
	output logic [63:0] cipher_low,
	output logic        last_out
);
	localparam int Depth = ROUNDS + 1;
	localparam int AW = $clog2(Depth);

	aes_pkg::state_t state_q, state_d;
	logic [AW-1:0] round_q, round_d, rd_addr;
	logic [127:0] block_q, block_d, key;
	logic last_q, last_d, accept, wr_en;

	assign accept = in_valid && !in_stall;
	assign wr_en = accept && !command && ({28'd0, round_index} <= 32'(ROUNDS));

	aes_ram #(.WIDTH(aes_pkg::KeyWidth), .DEPTH(Depth)) u_key_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(round_index[AW-1:0]),
		.wr_data({data_high, data_low}),
		.rd_addr(rd_addr),
		.rd_data(key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aes_pkg::ST_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

	always_ff @(posedge clk) begin
		block_q <= block_d;
		last_q <= last_d;
	end

	always_comb begin
		logic [127:0] ss;
		state_d = state_q;
		round_d = round_q;
		block_d = block_q;
		last_d = last_q;
		rd_addr = round_q;
		ss = aes_pkg::sub_shift(block_q ^ key);
		in_stall = (state_q != aes_pkg::ST_IDLE);
		out_valid = (state_q == aes_pkg::ST_DONE);
		case (state_q)
			aes_pkg::ST_IDLE: begin
				rd_addr = '0;
				if (accept && command) begin
					block_d = {data_high, data_low};
					last_d = last_block;
					round_d = '0;
					state_d = aes_pkg::ST_READ;
				end
			end
			aes_pkg::ST_READ: begin
				// key 0 arrives next cycle; fetch ahead by one
				rd_addr = round_q;
				round_d = round_q + AW'(1);
				state_d = aes_pkg::ST_ROUND;
			end
			aes_pkg::ST_ROUND: begin
				rd_addr = round_q;
				if (round_q == AW'(ROUNDS)) begin
					block_d = ss;
					round_d = AW'(ROUNDS);
					// final key add takes one more read, then done
					state_d = aes_pkg::ST_DONE;
				end else begin
					block_d = aes_pkg::mix_columns(ss);
					round_d = round_q + AW'(1);
				end
			end
			aes_pkg::ST_DONE: begin
				rd_addr = AW'(ROUNDS);
				if (!out_stall) begin
					state_d = aes_pkg::ST_IDLE;
				end
			end
			default: state_d = aes_pkg::ST_IDLE;
		endcase
	end

	// key ROUNDS stays on the read port while done
	assign cipher_high = block_q[127:64] ^ key[127:64];
	assign cipher_low = block_q[63:0] ^ key[63:0];
	assign last_out = last_q;
endmodule

// ===== rtl/aes_check.sv =====
module aes_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic command,
	input logic out_valid,
	input logic out_stall,
	input logic last_out
);
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("word taken while result pending");
	a_store_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !command) |=> !out_valid) else $error("store gave result");
	a_enc_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && command) |=> in_stall) else $error("encrypt not held");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(last_out))) else $error("result dropped");
endmodule

bind aes128_ecb_encrypt aes_check u_aes_check (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.command(command), .out_valid(out_valid), .out_stall(out_stall),
	.last_out(last_out)
);
